// ----- hdl/pcx_pkg.sv -----
// Shared types and constants for the permutation cycle crossover unit.
// No dependencies.
package pcx_pkg;

    localparam int VAL_W = 10;
    localparam int CNT_W = 11;
    localparam int MARK_W = 2;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [MARK_W-1:0] mark_t;

    localparam mark_t MARK_NONE = 2'd0;
    localparam mark_t MARK_EVEN = 2'd2;
    localparam mark_t MARK_ODD = 2'd3;

    localparam cnt_t COUNT_MAX = 11'd2047;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

endpackage

// ----- hdl/pcx_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pcx_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/permutation_cycle_crossover_unit.sv -----
// Cycle crossover of two parent permutations held in on-chip RAMs.
// Depends on pcx_pkg and pcx_ram.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | mode, position, value_a, value_b
// out     | output    | out_valid/out_ready| child_value, from_second, cycle_total, not_permutation
// cfg     | input     | cfg_wr_en          | cfg_wr_data (size_in_use)
//
// A load is written straight from idle. A read with valid labels goes through S_RD1 and S_RD2
// (RAM read) into the output register. The first read after a load or config write first labels
// the cycles: it clears marks and seen flags, checks both parents for duplicates, then walks the
// cycles, all bounded by the single read port of each RAM. in_ready is low during that time.
// Reset clears control state only; RAM contents are not cleared. A result held in the
// output register does not block the next load; a read waits there until it drains.
module permutation_cycle_crossover_unit #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  pcx_pkg::cnt_t cfg_wr_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          mode,
    input  pcx_pkg::val_t position,
    input  pcx_pkg::val_t value_a,
    input  pcx_pkg::val_t value_b,
    output logic          out_valid,
    input  logic          out_ready,
    output pcx_pkg::val_t child_value,
    output logic          from_second,
    output pcx_pkg::cnt_t cycle_total,
    output logic          not_permutation
);
    import pcx_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int NW = $clog2(MAX_ELEMENTS + 1);
    localparam int CW = (NW > CNT_W) ? NW : CNT_W;
    localparam logic [CW-1:0] MAX_CW = CW'(MAX_ELEMENTS);
    localparam logic [CW-1:0] MIN_CW = CW'(2);
    localparam logic [CW-1:0] RST_SIZE = CW'(1024);
    localparam logic [CW-1:0] N_RESET = (RST_SIZE > MAX_CW) ? MAX_CW : RST_SIZE;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_CHK_RD   = 4'd2;
    localparam logic [3:0] S_CHK_SEEN = 4'd3;
    localparam logic [3:0] S_CHK_UPD  = 4'd4;
    localparam logic [3:0] S_WS_RD    = 4'd5;
    localparam logic [3:0] S_WS_CHK   = 4'd6;
    localparam logic [3:0] S_W_MARK   = 4'd7;
    localparam logic [3:0] S_W_B      = 4'd8;
    localparam logic [3:0] S_W_INV    = 4'd9;
    localparam logic [3:0] S_W_CHKM   = 4'd10;
    localparam logic [3:0] S_W_END    = 4'd11;
    localparam logic [3:0] S_NEXT     = 4'd12;
    localparam logic [3:0] S_RD1      = 4'd13;
    localparam logic [3:0] S_RD2      = 4'd14;

    function automatic logic [CW-1:0] ext_val(input val_t v);
        return {{(CW-VAL_W){1'b0}}, v};
    endfunction

    function automatic logic [CW-1:0] ext_cnt(input cnt_t v);
        return CW'(v);
    endfunction

    function automatic logic [AW-1:0] val_addr(input val_t v);
        logic [CW-1:0] wide;
        wide = ext_val(v);
        return wide[AW-1:0];
    endfunction

    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] steps_reg, steps_next;
    val_t          va_reg, va_next;
    val_t          vb_reg, vb_next;
    val_t          pos_reg, pos_next;
    mark_t         markv_reg, markv_next;
    cnt_t          cnt_reg, cnt_next;
    logic          bad_reg, bad_next;
    logic          labels_reg, labels_next;
    logic          out_valid_reg, out_valid_next;
    val_t          child_reg, child_next;
    logic          second_reg, second_next;
    cnt_t          total_reg, total_next;
    logic          notperm_reg, notperm_next;

    logic            par_we;
    logic [AW-1:0]   par_waddr, par_raddr;
    logic [2*VAL_W-1:0] par_wdata, par_rdata;
    logic            inv_we;
    logic [AW-1:0]   inv_waddr, inv_raddr;
    val_t            inv_wdata, inv_rdata;
    logic            mark_we;
    logic [AW-1:0]   mark_waddr, mark_raddr;
    mark_t           mark_wdata, mark_rdata;
    logic            sa_we, sb_we;
    logic [AW-1:0]   sa_waddr, sa_raddr, sb_waddr, sb_raddr;
    logic            sa_wdata, sa_rdata, sb_wdata, sb_rdata;

    logic [CW-1:0] n_cw;
    logic [CW-1:0] n_last;
    logic [CW-1:0] cfg_size;
    logic [CW-1:0] cfg_clamped;

    assign n_cw = CW'(n_reg);
    assign n_last = n_cw - CW'(1);
    assign cfg_size = ext_cnt(cfg_wr_data);
    assign cfg_clamped = (cfg_size < MIN_CW) ? MIN_CW :
                         (cfg_size > MAX_CW) ? MAX_CW : cfg_size;

    assign in_ready = (state_reg == S_IDLE);

    pcx_ram #(.WIDTH(2*VAL_W), .DEPTH(MAX_ELEMENTS)) u_par_ram (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    pcx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_inv_ram (
        .clk(clk), .we(inv_we), .waddr(inv_waddr), .wdata(inv_wdata),
        .raddr(inv_raddr), .rdata(inv_rdata)
    );

    pcx_ram #(.WIDTH(MARK_W), .DEPTH(MAX_ELEMENTS)) u_mark_ram (
        .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
        .raddr(mark_raddr), .rdata(mark_rdata)
    );

    pcx_ram #(.WIDTH(1), .DEPTH(MAX_ELEMENTS)) u_seen_a_ram (
        .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata),
        .raddr(sa_raddr), .rdata(sa_rdata)
    );

    pcx_ram #(.WIDTH(1), .DEPTH(MAX_ELEMENTS)) u_seen_b_ram (
        .clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(sb_wdata),
        .raddr(sb_raddr), .rdata(sb_rdata)
    );

    always_comb
    begin
        logic [CW-1:0] new_cur;
        logic [CW-1:0] steps_inc;
        logic [CW-1:0] pa_val;
        logic [CW-1:0] pb_val;

        new_cur = ext_val(inv_rdata);
        steps_inc = steps_reg + CW'(1);
        pa_val = ext_val(par_rdata[2*VAL_W-1:VAL_W]);
        pb_val = ext_val(par_rdata[VAL_W-1:0]);

        state_next = state_reg;
        n_next = n_reg;
        idx_next = idx_reg;
        cur_next = cur_reg;
        steps_next = steps_reg;
        va_next = va_reg;
        vb_next = vb_reg;
        pos_next = pos_reg;
        markv_next = markv_reg;
        cnt_next = cnt_reg;
        bad_next = bad_reg;
        labels_next = labels_reg;
        out_valid_next = out_valid_reg;
        child_next = child_reg;
        second_next = second_reg;
        total_next = total_reg;
        notperm_next = notperm_reg;

        par_we = 1'b0;
        par_waddr = val_addr(position);
        par_wdata = {value_a, value_b};
        par_raddr = idx_reg[AW-1:0];
        inv_we = 1'b0;
        inv_waddr = val_addr(value_a);
        inv_wdata = position;
        inv_raddr = pb_val[AW-1:0];
        mark_we = 1'b0;
        mark_waddr = idx_reg[AW-1:0];
        mark_wdata = MARK_NONE;
        mark_raddr = idx_reg[AW-1:0];
        sa_we = 1'b0;
        sa_waddr = idx_reg[AW-1:0];
        sa_wdata = 1'b0;
        sa_raddr = pa_val[AW-1:0];
        sb_we = 1'b0;
        sb_waddr = idx_reg[AW-1:0];
        sb_wdata = 1'b0;
        sb_raddr = pb_val[AW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        if (ext_val(position) < n_cw)
                        begin
                            par_we = 1'b1;
                            inv_we = (ext_val(value_a) < n_cw);
                            labels_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pos_next = position;
                        idx_next = '0;
                        state_next = labels_reg ? S_RD1 : S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                mark_we = 1'b1;
                sa_we = 1'b1;
                sb_we = 1'b1;
                if (idx_reg == n_last)
                begin
                    idx_next = '0;
                    bad_next = 1'b0;
                    state_next = S_CHK_RD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_SEEN;
            end
            S_CHK_SEEN:
            begin
                va_next = par_rdata[2*VAL_W-1:VAL_W];
                vb_next = par_rdata[VAL_W-1:0];
                state_next = S_CHK_UPD;
            end
            S_CHK_UPD:
            begin
                sa_waddr = val_addr(va_reg);
                sa_wdata = 1'b1;
                sb_waddr = val_addr(vb_reg);
                sb_wdata = 1'b1;
                if ((ext_val(va_reg) >= n_cw) || sa_rdata)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    sa_we = 1'b1;
                end
                if ((ext_val(vb_reg) >= n_cw) || sb_rdata)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    sb_we = 1'b1;
                end
                if (idx_reg == n_last)
                begin
                    idx_next = '0;
                    cnt_next = '0;
                    state_next = S_WS_RD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_CHK_RD;
                end
            end
            S_WS_RD:
            begin
                state_next = S_WS_CHK;
            end
            S_WS_CHK:
            begin
                if (mark_rdata != MARK_NONE)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cur_next = idx_reg;
                    steps_next = '0;
                    markv_next = cnt_reg[0] ? MARK_ODD : MARK_EVEN;
                    state_next = S_W_MARK;
                end
            end
            S_W_MARK:
            begin
                mark_we = 1'b1;
                mark_waddr = cur_reg[AW-1:0];
                mark_wdata = markv_reg;
                par_raddr = cur_reg[AW-1:0];
                state_next = S_W_B;
            end
            S_W_B:
            begin
                state_next = (pb_val >= n_cw) ? S_W_END : S_W_INV;
            end
            S_W_INV:
            begin
                steps_next = steps_inc;
                cur_next = new_cur;
                mark_raddr = new_cur[AW-1:0];
                if ((steps_inc >= n_cw) || (new_cur >= n_cw))
                begin
                    state_next = S_W_END;
                end
                else
                begin
                    state_next = S_W_CHKM;
                end
            end
            S_W_CHKM:
            begin
                state_next = (mark_rdata != MARK_NONE) ? S_W_END : S_W_MARK;
            end
            S_W_END:
            begin
                if (cnt_reg != COUNT_MAX)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (idx_reg == n_last)
                begin
                    labels_next = 1'b1;
                    state_next = S_RD1;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_WS_RD;
                end
            end
            S_RD1:
            begin
                par_raddr = val_addr(pos_reg);
                mark_raddr = val_addr(pos_reg);
                state_next = S_RD2;
            end
            S_RD2:
            begin
                // keep the read address so the data holds while the output is busy
                par_raddr = val_addr(pos_reg);
                mark_raddr = val_addr(pos_reg);
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    total_next = cnt_reg;
                    notperm_next = bad_reg;
                    if (ext_val(pos_reg) < n_cw)
                    begin
                        if (mark_rdata == MARK_ODD)
                        begin
                            child_next = par_rdata[VAL_W-1:0];
                            second_next = 1'b1;
                        end
                        else
                        begin
                            child_next = par_rdata[2*VAL_W-1:VAL_W];
                            second_next = 1'b0;
                        end
                    end
                    else
                    begin
                        child_next = '0;
                        second_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            n_next = cfg_clamped[NW-1:0];
            labels_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg <= N_RESET[NW-1:0];
            idx_reg <= '0;
            cur_reg <= '0;
            steps_reg <= '0;
            va_reg <= '0;
            vb_reg <= '0;
            pos_reg <= '0;
            markv_reg <= MARK_NONE;
            cnt_reg <= '0;
            bad_reg <= 1'b0;
            labels_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            child_reg <= '0;
            second_reg <= 1'b0;
            total_reg <= '0;
            notperm_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            idx_reg <= idx_next;
            cur_reg <= cur_next;
            steps_reg <= steps_next;
            va_reg <= va_next;
            vb_reg <= vb_next;
            pos_reg <= pos_next;
            markv_reg <= markv_next;
            cnt_reg <= cnt_next;
            bad_reg <= bad_next;
            labels_reg <= labels_next;
            out_valid_reg <= out_valid_next;
            child_reg <= child_next;
            second_reg <= second_next;
            total_reg <= total_next;
            notperm_reg <= notperm_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign child_value = child_reg;
    assign from_second = second_reg;
    assign cycle_total = total_reg;
    assign not_permutation = notperm_reg;

endmodule

// ----- sim/crossover_checker.sv -----
// Crossover checker: follows loads, reads and size writes on the unit's ports,
// predicts each child result from its own copy of the parents and compares it.
// Depends on pcx_pkg.
module crossover_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  pcx_pkg::cnt_t cfg_wr_data,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic          mode,
    input  pcx_pkg::val_t position,
    input  pcx_pkg::val_t value_a,
    input  pcx_pkg::val_t value_b,
    input  logic          out_valid,
    input  logic          out_ready,
    input  pcx_pkg::val_t child_value,
    input  logic          from_second,
    input  pcx_pkg::cnt_t cycle_total,
    input  logic          not_permutation,
    output int            child_pending,
    output int            error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pcx_pkg::*;

    localparam int DEPTH = 1024;

    typedef struct packed {
        val_t child;
        logic second;
        cnt_t total;
        logic bad;
    } child_t;

    val_t   first_parent [DEPTH];
    val_t   second_parent [DEPTH];
    val_t   first_inverse [DEPTH];
    mark_t  cycle_mark [DEPTH];
    logic   marks_valid;
    cnt_t   cycles_found;
    logic   not_perm;
    cnt_t   size_reg;
    child_t child_due [$];
    int     mismatches;

    function automatic int active_size();
        int n;
        n = size_reg;
        if (n < 2)
            n = 2;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    function automatic void mark_cycles();
        int    n;
        int    cur;
        int    steps;
        bit    walking;
        bit    bad;
        mark_t tag;
        bit    seen_a [DEPTH];
        bit    seen_b [DEPTH];
        n = active_size();
        bad = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            seen_a[i] = 1'b0;
            seen_b[i] = 1'b0;
            cycle_mark[i] = MARK_NONE;
        end
        for (int i = 0; i < n; i++)
        begin
            if (first_parent[i] >= n || seen_a[first_parent[i]])
                bad = 1'b1;
            else
                seen_a[first_parent[i]] = 1'b1;
            if (second_parent[i] >= n || seen_b[second_parent[i]])
                bad = 1'b1;
            else
                seen_b[second_parent[i]] = 1'b1;
        end
        cycles_found = '0;
        for (int s = 0; s < n; s++)
        begin
            if (cycle_mark[s] == MARK_NONE)
            begin
                tag = cycles_found[0] ? MARK_ODD : MARK_EVEN;
                cur = s;
                steps = 0;
                walking = 1'b1;
                while (walking && steps < n && cur < n && cycle_mark[cur] == MARK_NONE)
                begin
                    cycle_mark[cur] = tag;
                    if (second_parent[cur] >= n)
                        walking = 1'b0;
                    else
                    begin
                        cur = first_inverse[second_parent[cur]];
                        steps++;
                    end
                end
                if (cycles_found != COUNT_MAX)
                    cycles_found++;
            end
        end
        not_perm = bad;
        marks_valid = 1'b1;
    endfunction

    function automatic void take_item(logic m, val_t pos, val_t va, val_t vb);
        int     n;
        child_t r;
        n = active_size();
        if (m == MODE_LOAD)
        begin
            if (pos < n)
            begin
                first_parent[pos] = va;
                second_parent[pos] = vb;
                if (va < n)
                    first_inverse[va] = pos;
                marks_valid = 1'b0;
            end
        end
        else
        begin
            if (!marks_valid)
                mark_cycles();
            r.child = '0;
            r.second = 1'b0;
            if (pos < n)
            begin
                if (cycle_mark[pos] == MARK_ODD)
                begin
                    r.child = second_parent[pos];
                    r.second = 1'b1;
                end
                else
                    r.child = first_parent[pos];
            end
            r.total = cycles_found;
            r.bad = not_perm;
            child_due.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        child_t exp_child;
        if (!rst_n)
        begin
            size_reg = 11'd1024;
            marks_valid = 1'b0;
            cycles_found = '0;
            not_perm = 1'b0;
            child_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (child_due.size() == 0)
                begin
                    $error("unexpected result transaction: child_value %0d", child_value);
                    mismatches++;
                end
                else
                begin
                    exp_child = child_due.pop_front();
                    check_field("child_value", exp_child.child, child_value);
                    check_field("from_second", exp_child.second, from_second);
                    check_field("cycle_total", exp_child.total, cycle_total);
                    check_field("not_permutation", exp_child.bad, not_permutation);
                end
            end
            if (cfg_wr_en)
            begin
                size_reg = cfg_wr_data;
                marks_valid = 1'b0;
            end
            if (in_valid && in_ready)
                take_item(mode, position, value_a, value_b);
        end
        child_pending <= child_due.size();
        error_count <= mismatches;
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the crossover testbench: clock, reset, load/read stimulus and size writes.
// Depends on pcx_pkg, permutation_cycle_crossover_unit and crossover_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcx_pkg::*;

    localparam int DEPTH = 1024;
    localparam int PERIOD = 4;
    localparam int STALL_LIMIT = 60000;
    localparam int ITEM_TARGET = 1100;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    cnt_t cfg_wr_data;
    logic in_valid;
    logic in_ready;
    logic mode;
    val_t position;
    val_t value_a;
    val_t value_b;
    logic out_valid;
    logic out_ready;
    val_t child_value;
    logic from_second;
    cnt_t cycle_total;
    logic not_permutation;

    int child_pending;
    int error_count;
    int stuck;
    int sent;
    int cur_n;
    bit steady;
    int first_copy [DEPTH];
    int second_copy [DEPTH];
    int perm_buf [3][DEPTH];

    always #(PERIOD / 2) clk = ~clk;

    permutation_cycle_crossover_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .position        (position),
        .value_a         (value_a),
        .value_b         (value_b),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .child_value     (child_value),
        .from_second     (from_second),
        .cycle_total     (cycle_total),
        .not_permutation (not_permutation)
    );

    crossover_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .position        (position),
        .value_a         (value_a),
        .value_b         (value_b),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .child_value     (child_value),
        .from_second     (from_second),
        .cycle_total     (cycle_total),
        .not_permutation (not_permutation),
        .child_pending   (child_pending),
        .error_count     (error_count)
    );

    function automatic int pick_wait();
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic int clamp_size(int v);
        if (v < 2)
            return 2;
        if (v > DEPTH)
            return DEPTH;
        return v;
    endfunction

    function automatic void shuffle(int which, int n);
        int j;
        int t;
        for (int k = 0; k < n; k++)
            perm_buf[which][k] = k;
        for (int k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = perm_buf[which][k];
            perm_buf[which][k] = perm_buf[which][j];
            perm_buf[which][j] = t;
        end
    endfunction

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send(logic m, int pos, int va, int vb);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        position <= val_t'(pos);
        value_a <= val_t'(va);
        value_b <= val_t'(vb);
        do @(posedge clk); while (!in_ready);
        sent++;
        if (m == MODE_LOAD && pos < cur_n)
        begin
            first_copy[pos] = va;
            second_copy[pos] = vb;
        end
    endtask

    task automatic load(int pos, int va, int vb);
        send(MODE_LOAD, pos, va, vb);
    endtask

    task automatic read(int pos);
        send(MODE_READ, pos, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (child_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(int v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cnt_t'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_n = clamp_size(v);
    endtask

    task automatic swap_pair();
        int i;
        int j;
        int ai;
        int aj;
        i = $urandom_range(0, cur_n - 1);
        j = (i + $urandom_range(1, cur_n - 1)) % cur_n;
        ai = first_copy[i];
        aj = first_copy[j];
        load(i, aj, second_copy[i]);
        load(j, ai, second_copy[j]);
    endtask

    task automatic corrupt();
        int pos;
        int kind;
        kind = $urandom_range(0, 2);
        if (kind == 2 && cur_n == DEPTH)
            kind = 0;
        pos = $urandom_range(0, cur_n - 1);
        case (kind)
            0: load(pos, $urandom_range(0, 1023), second_copy[pos]);
            1: load(pos, first_copy[pos], $urandom_range(0, 1023));
            default: load($urandom_range(cur_n, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023));
        endcase
    endtask

    task automatic run_phase(int size_value, bit reload, int reads);
        int pos;
        write_size(size_value);
        if (reload)
        begin
            shuffle(0, cur_n);
            shuffle(1, cur_n);
            shuffle(2, cur_n);
            for (int k = 0; k < cur_n; k++)
            begin
                pos = perm_buf[2][k];
                load(pos, perm_buf[0][pos], perm_buf[1][pos]);
            end
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) corrupt();
        for (int r = 0; r < reads; r++)
        begin
            if (cur_n <= 64 && $urandom_range(0, 9) == 0)
                swap_pair();
            if ($urandom_range(0, 29) == 0)
                drain();
            if ($urandom_range(0, 7) == 0)
                pos = $urandom_range(0, 1023);
            else
                pos = $urandom_range(0, cur_n - 1);
            read(pos);
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : result_side
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = pick_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int phase;
        int size_value;
        int pick;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        mode <= MODE_LOAD;
        position <= '0;
        value_a <= '0;
        value_b <= '0;
        sent = 0;
        steady = 1'b0;
        cur_n = DEPTH;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size below range, read and load beyond the size
        write_size(1);
        load(1, 0, 1);
        load(0, 1, 0);
        read(0);
        read(1023);
        load(700, 5, 6);
        read(1);
        drain();

        // positions 0 and 1 form the even cycle and positions 2 and 3 the odd one, taken from the second parent
        write_size(4);
        load(0, 0, 1);
        load(1, 1, 0);
        load(2, 2, 3);
        load(3, 3, 2);
        for (int k = 0; k < 4; k++)
            read(k);
        // first parent value out of range, then second parent value out of range
        load(2, 1023, 3);
        read(2);
        load(3, 3, 1023);
        read(3);
        drain();

        phase = 0;
        while (sent < ITEM_TARGET || phase < 6)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if (phase == 3)
                run_phase(DEPTH, 1'b1, 48);
            else if (phase == 4)
                run_phase(2047, 1'b0, 24);
            else if (phase == 5)
                run_phase(1025, 1'b0, 8);
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    size_value = 0;
                else if (pick == 1)
                    size_value = 1;
                else if (pick == 2)
                    size_value = $urandom_range(17, 64);
                else
                    size_value = $urandom_range(2, 16);
                run_phase(size_value, 1'b1, $urandom_range(1, 2 * clamp_size(size_value) + 2));
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
